// ===== hw/rtl/ffa_pkg.sv =====
package ffa_pkg;

	localparam int FREE_SEGMENTS_DEF = 16;
	localparam int ALLOC_RECORDS_DEF = 16;
	localparam int ADDR_BITS_DEF     = 20;
	localparam int HEADER_BYTES_DEF  = 8;

	localparam int CFG_DATA_W = 21;
	localparam int CFG_IDX_W  = 1;

	localparam logic [CFG_IDX_W-1:0] REG_POOL_BASE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_POOL_SIZE = 1'd1;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_NO_FIT  = 2'd1,
		ST_UNKNOWN = 2'd2,
		ST_FULL    = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_A_RD,
		S_A_CHK,
		S_F_RD,
		S_F_CHK,
		S_F_SRD,
		S_F_SCHK,
		S_F_DEC,
		S_SH_RD,
		S_SH_WR,
		S_DONE
	} state_t;

endpackage

// ===== hw/rtl/ffa_if.sv =====
interface ffa_req_if;
	logic        valid;
	logic        ready;
	logic        op;
	logic [20:0] req_size;
	logic [3:0]  align_log2;
	logic [19:0] free_addr;
	modport source (output valid, op, req_size, align_log2, free_addr, input ready);
	modport sink   (input valid, op, req_size, align_log2, free_addr, output ready);
endinterface

interface ffa_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [19:0] data_addr;
	logic [4:0]  live_count;
	modport source (output valid, status, data_addr, live_count, input ready);
	modport sink   (input valid, status, data_addr, live_count, output ready);
endinterface

// ===== hw/rtl/ffa_ram.sv =====
module ffa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                        clk,
	input  logic                                        we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                            wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                            rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== hw/rtl/first_fit_free_list_allocator_core.sv =====
// First-fit free-list allocator.
// Requests arrive on req (op, req_size, align_log2, free_addr); one response per
// request leaves on rsp (status, data_addr, live_count). cfg_we/cfg_idx/cfg_data
// write pool_base (index 0) or pool_size (index 1); either write re-initialises
// the pool as one free segment (none if its clipped length is zero) and drops every record. Write config only idle.
// Free segments (base,len) live in one RAM and allocation records
// (data,start,len) in another; record valid bits are flip-flops.
// An allocate walks the segments in order to the first fit, shifts the table down
// on an exact fit, then posts the response. A free walks the records to find its
// own, walks the segments to find its place, decides, then makes a single merge,
// makes a double merge or opens a gap, then posts the response. Both kinds of walk
// are set by the single read port of each memory.
// One request is worked at a time; req.ready is high only when idle.
// The response sits in an output register until rsp.ready; the next request is
// still taken and worked, and its response waits in the last state until the
// register frees. Reset gives pool base 0, size 2^20, no records; the first
// cycle after reset writes that segment and keeps req.ready low.
module first_fit_free_list_allocator_core import ffa_pkg::*; #(
	parameter int FREE_SEGMENTS = FREE_SEGMENTS_DEF,
	parameter int ALLOC_RECORDS = ALLOC_RECORDS_DEF,
	parameter int HEADER_BYTES  = HEADER_BYTES_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	ffa_req_if.sink               req,
	ffa_rsp_if.source             rsp
);
	localparam int SW = $clog2(FREE_SEGMENTS);
	localparam int RW = (ALLOC_RECORDS > 1) ? $clog2(ALLOC_RECORDS) : 1;
	localparam int CW = $clog2(FREE_SEGMENTS + 1);
	localparam int LW = $clog2(ALLOC_RECORDS + 1);
	localparam int AW = ADDR_BITS_DEF;
	localparam int NW = AW + 1;  // lengths, up to 2^AW
	localparam int XW = AW + 2;  // sums of address and length
	localparam logic [XW-1:0] SPACE = XW'(1) << AW;

	state_t state_q, state_d;

	logic          init_q;     // first cycle after reset: write the pool segment
	logic [AW-1:0] pool_base_q;
	logic [NW-1:0] pool_size_q;
	logic [CW-1:0] seg_count_q;
	logic [LW-1:0] live_q;
	logic [ALLOC_RECORDS-1:0] rec_valid_q;

	logic [20:0]   size_q;
	logic [3:0]    lg_q;
	logic [AW-1:0] faddr_q;
	logic [CW-1:0] idx_q;      // walk index
	logic [RW-1:0] rec_q;      // chosen record
	logic [AW-1:0] s_q;        // freed start
	logic [NW-1:0] l_q;        // freed length
	logic          prv_q;      // previous segment exists
	logic [XW-1:0] prv_end_q;  // end of previous segment
	logic [AW-1:0] prv_base_q;
	logic [NW-1:0] prv_len_q;
	logic          up_q;       // shift direction: 1 = open a gap
	logic [CW-1:0] sh_end_q;   // shift stop index
	logic [AW-1:0] carry_b_q;  // entry to write at the stop
	logic [NW-1:0] carry_l_q;

	logic [1:0]    st_q;
	logic [AW-1:0] da_q;

	// response output register
	logic          rsp_v_q;
	logic [1:0]    rsp_st_q;
	logic [AW-1:0] rsp_da_q;
	logic [LW-1:0] rsp_live_q;
	logic          rsp_load;

	// RAM ports
	logic          sw_e;
	logic [SW-1:0] sw_a, sr_a;
	logic [AW+NW-1:0] sw_d, sr_d;
	logic          rw_e;
	logic [RW-1:0] rw_a, rr_a;
	logic [2*AW+NW-1:0] rw_d, rr_d;

	ffa_ram #(.WIDTH(AW + NW), .DEPTH(FREE_SEGMENTS)) u_seg (
		.clk, .we(sw_e), .waddr(sw_a), .wdata(sw_d), .raddr(sr_a), .rdata(sr_d)
	);
	ffa_ram #(.WIDTH(2 * AW + NW), .DEPTH(ALLOC_RECORDS)) u_rec (
		.clk, .we(rw_e), .waddr(rw_a), .wdata(rw_d), .raddr(rr_a), .rdata(rr_d)
	);

	logic [AW-1:0] sb;
	logic [NW-1:0] sl;
	assign sb = sr_d[AW+NW-1:NW];
	assign sl = sr_d[NW-1:0];

	// allocate fit math
	logic [XW-1:0] amask, pad, need, bplus;
	assign amask = (XW'(1) << lg_q) - XW'(1);
	assign bplus = XW'(sb) + XW'(HEADER_BYTES);
	assign pad   = XW'(HEADER_BYTES) + ((amask + XW'(1) - (bplus & amask)) & amask);
	assign need  = XW'(size_q) + pad;
	logic fits, exact;
	assign fits  = XW'(sl) >= need;
	assign exact = XW'(sl) == need;

	// free records
	logic          has_free_rec;
	logic [RW-1:0] free_rec;
	always_comb begin
		has_free_rec = 1'b0;
		free_rec = '0;
		for (int i = ALLOC_RECORDS - 1; i >= 0; i--) begin
			if (!rec_valid_q[i]) begin
				has_free_rec = 1'b1;
				free_rec = RW'(i);
			end
		end
	end

	logic [XW-1:0] fend;
	assign fend = XW'(s_q) + XW'(l_q);
	logic at_end;
	assign at_end = idx_q >= seg_count_q;

	// clipped init length
	logic [XW-1:0] room, init_len;
	logic [AW-1:0] init_base;
	logic [NW-1:0] init_size;
	always_comb begin
		init_base = pool_base_q;
		init_size = pool_size_q;
		if (cfg_we && cfg_idx == REG_POOL_BASE) init_base = AW'(cfg_data);
		if (cfg_we && cfg_idx == REG_POOL_SIZE) init_size = NW'(cfg_data);
		room = SPACE - XW'(init_base);
		init_len = (XW'(init_size) > room) ? room : XW'(init_size);
	end

	assign req.ready = state_q == S_IDLE && !init_q;
	assign rsp.valid = rsp_v_q;
	assign rsp.status = rsp_st_q;
	assign rsp.data_addr = 20'(rsp_da_q);
	assign rsp.live_count = 5'(rsp_live_q);

	assign rsp_load = state_q == S_DONE && (!rsp_v_q || rsp.ready);

	// memory addressing and writes
	logic          dec_mn, dec_mp;
	assign dec_mn = !at_end && state_q == S_F_DEC && fend == XW'(sb);
	assign dec_mp = prv_q && prv_end_q == XW'(s_q);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:   if (req.valid && req.ready) state_d = req.op ? S_F_RD : S_A_RD;
			S_A_RD:   state_d = S_A_CHK;
			S_A_CHK:  state_d = (!has_free_rec || at_end) ? S_DONE :
			                    (fits ? (exact ? S_SH_RD : S_DONE) : S_A_RD);
			S_F_RD:   state_d = S_F_CHK;
			S_F_CHK:  state_d = (rec_valid_q[rec_q] && rr_d[2*AW+NW-1:AW+NW] == faddr_q)
			                    ? S_F_SRD
			                    : ((32'(rec_q) == ALLOC_RECORDS - 1) ? S_DONE : S_F_RD);
			S_F_SRD:  state_d = at_end ? S_F_DEC : S_F_SCHK;
			S_F_SCHK: state_d = (sb > s_q) ? S_F_DEC : S_F_SRD;
			S_F_DEC: begin
				if (!dec_mn && !dec_mp && 32'(seg_count_q) >= FREE_SEGMENTS) state_d = S_DONE;
				else if (dec_mp && dec_mn) state_d = S_SH_RD;
				else if (dec_mp || dec_mn) state_d = S_SH_WR;
				else state_d = (idx_q == seg_count_q) ? S_SH_WR : S_SH_RD;
			end
			S_SH_RD:  state_d = S_SH_WR;
			S_SH_WR:  state_d = (idx_q == sh_end_q) ? S_DONE : S_SH_RD;
			S_DONE:   if (!rsp_v_q || rsp.ready) state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	always_comb begin
		sr_a = SW'(idx_q);
		rr_a = rec_q;
		sw_e = 1'b0; sw_a = SW'(idx_q); sw_d = {sb, sl};
		rw_e = 1'b0; rw_a = rec_q; rw_d = '0;
		unique case (state_q)
			S_SH_RD: sr_a = up_q ? SW'(idx_q - CW'(1)) : SW'(idx_q + CW'(1));
			S_SH_WR: begin
				sw_e = 1'b1;
				sw_d = (idx_q == sh_end_q) ? {carry_b_q, carry_l_q} : {sb, sl};
			end
			S_A_CHK: begin
				if (has_free_rec && !at_end && fits) begin
					rw_e = 1'b1;
					rw_a = free_rec;
					rw_d = {AW'(XW'(sb) + pad), sb, NW'(need)};
					if (!exact) begin
						sw_e = 1'b1;
						sw_d = {AW'(XW'(sb) + need), NW'(XW'(sl) - need)};
					end
				end
			end
			S_F_DEC: begin
				// double merge: grow the entry below, then close the gap at k
				if (dec_mp && dec_mn) begin
					sw_e = 1'b1;
					sw_a = SW'(idx_q - CW'(1));
					sw_d = {prv_base_q, NW'(XW'(prv_len_q) + XW'(l_q) + XW'(sl))};
				end
			end
			default: ;
		endcase
		if (cfg_we || init_q) begin
			sw_e = 1'b1; sw_a = '0; sw_d = {init_base, NW'(init_len)};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			init_q      <= 1'b1;
			pool_base_q <= '0;
			pool_size_q <= NW'(SPACE);
			seg_count_q <= CW'(1);
			live_q      <= '0;
			rec_valid_q <= '0;
			rsp_v_q     <= 1'b0;
			rsp_st_q    <= ST_OK;
			rsp_da_q    <= '0;
			rsp_live_q  <= '0;
		end else begin
			state_q <= state_d;
			init_q  <= 1'b0;
			if (rsp_load) begin
				rsp_v_q    <= 1'b1;
				rsp_st_q   <= st_q;
				rsp_da_q   <= da_q;
				rsp_live_q <= live_q;
			end else if (rsp.ready) begin
				rsp_v_q <= 1'b0;
			end
			if (cfg_we) begin
				pool_base_q <= init_base;
				pool_size_q <= init_size;
				seg_count_q <= (init_len != '0) ? CW'(1) : '0;
				rec_valid_q <= '0;
				live_q <= '0;
			end else begin
				unique case (state_q)
					S_A_CHK: begin
						if (has_free_rec && !at_end && fits) begin
							rec_valid_q[free_rec] <= 1'b1;
							live_q <= live_q + LW'(1);
							if (exact) begin
								seg_count_q <= seg_count_q - CW'(1);
							end
						end
					end
					S_F_DEC: begin
						if (dec_mn || dec_mp || 32'(seg_count_q) < FREE_SEGMENTS) begin
							rec_valid_q[rec_q] <= 1'b0;
							live_q <= live_q - LW'(1);
							if (dec_mp && dec_mn) begin
								seg_count_q <= seg_count_q - CW'(1);
							end else if (!dec_mp && !dec_mn) begin
								seg_count_q <= seg_count_q + CW'(1);
							end
						end
					end
					default: ;
				endcase
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				size_q <= req.req_size; lg_q <= req.align_log2;
				faddr_q <= AW'(req.free_addr);
				idx_q <= '0; rec_q <= '0; prv_q <= 1'b0;
				st_q <= ST_OK; da_q <= '0;
			end
			S_A_CHK: begin
				if (!has_free_rec) st_q <= ST_FULL;
				else if (at_end) st_q <= ST_NO_FIT;
				else if (fits) begin
					da_q <= AW'(XW'(sb) + pad);
					up_q <= 1'b0;
					sh_end_q <= seg_count_q - CW'(1);
					if (exact) begin
						// shift down from idx; the slot past the new end gets a stale copy
						carry_b_q <= sb; carry_l_q <= sl;
					end
				end else idx_q <= idx_q + CW'(1);
			end
			S_F_CHK: begin
				s_q <= rr_d[AW+NW-1:NW];
				l_q <= rr_d[NW-1:0];
				if (!(rec_valid_q[rec_q] && rr_d[2*AW+NW-1:AW+NW] == faddr_q)) begin
					rec_q <= rec_q + RW'(1);
					if (32'(rec_q) == ALLOC_RECORDS - 1) st_q <= ST_UNKNOWN;
				end
			end
			S_F_SCHK: begin
				if (!(sb > s_q)) begin
					prv_q <= 1'b1; prv_base_q <= sb; prv_len_q <= sl;
					prv_end_q <= XW'(sb) + XW'(sl);
					idx_q <= idx_q + CW'(1);
				end
			end
			S_F_DEC: begin
				if (!dec_mn && !dec_mp && 32'(seg_count_q) >= FREE_SEGMENTS) st_q <= ST_FULL;
				else if (dec_mp && dec_mn) begin
					// merged entry at k-1 written now; close the gap from k up
					up_q <= 1'b0;
					sh_end_q <= seg_count_q - CW'(1);
					carry_b_q <= sb;
					carry_l_q <= sl;
				end else if (dec_mp) begin
					idx_q <= idx_q - CW'(1);
					sh_end_q <= idx_q - CW'(1);
					carry_b_q <= prv_base_q;
					carry_l_q <= NW'(XW'(prv_len_q) + XW'(l_q));
				end else if (dec_mn) begin
					sh_end_q <= idx_q;
					carry_b_q <= s_q;
					carry_l_q <= NW'(XW'(l_q) + XW'(sl));
				end else begin
					// open a gap at k, walking down from seg_count
					idx_q <= seg_count_q;
					up_q <= 1'b1;
					sh_end_q <= idx_q;
					carry_b_q <= s_q;
					carry_l_q <= l_q;
				end
			end
			S_SH_WR: begin
				if (idx_q != sh_end_q) idx_q <= up_q ? idx_q - CW'(1) : idx_q + CW'(1);
			end
			default: ;
		endcase
	end

	ffa_init_ok: assert property (@(posedge clk) disable iff (!arst_n)
		init_q |-> !req.ready)
		else $error("request taken before the pool segment is written");
	ffa_live_ok: assert property (@(posedge clk) disable iff (!arst_n)
		32'(live_q) == $countones(rec_valid_q))
		else $error("live count differs from valid records");
	ffa_segcnt_ok: assert property (@(posedge clk) disable iff (!arst_n)
		32'(seg_count_q) <= FREE_SEGMENTS)
		else $error("segment count overflow");
	ffa_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_v_q && !rsp.ready) |=> rsp_v_q)
		else $error("response dropped");
	ffa_rsp_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_v_q && !rsp.ready) |=> $stable({rsp_st_q, rsp_da_q, rsp_live_q}))
		else $error("response changed while waiting");
endmodule

// ===== bench/tb_first_fit_free_list_allocator_core.sv =====
`timescale 1ns / 1ps

module tb_first_fit_free_list_allocator_core;
	import ffa_pkg::*;

	localparam int NSEG = 16;
	localparam int NREC = 16;
	localparam int HDR = 8;
	localparam longint SPACE = 64'd1 << 20;
	localparam int IDLE_LIMIT = 4000;

	typedef struct packed {
		logic        op;
		logic [20:0] req_size;
		logic [3:0]  align_log2;
		logic [19:0] free_addr;
	} alloc_req_t;

	typedef struct packed {
		status_t     status;
		logic [19:0] data_addr;
		logic [4:0]  live_count;
	} alloc_rsp_t;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_idx = REG_POOL_BASE;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	ffa_req_if req_ch();
	ffa_rsp_if rsp_ch();

	first_fit_free_list_allocator_core dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
		.cfg_data(cfg_data), .req(req_ch.sink), .rsp(rsp_ch.source)
	);

	always #5 clk = ~clk;

	// Shadow pool: free segments sorted by address plus allocation records.
	longint pool_base_q = 0;
	longint pool_size_q = SPACE;
	longint seg_b[NSEG + 1];
	longint seg_l[NSEG + 1];
	int     seg_n;
	longint rec_d[NREC];
	longint rec_s[NREC];
	longint rec_l[NREC];
	bit     rec_v[NREC];
	int     live_n;

	alloc_req_t pending_reqs[$];
	alloc_rsp_t expected_rsps[$];
	int  errors = 0;
	int  send_idle_pct = 0;
	int  recv_stall_pct = 0;
	bit  send_hold = 1'b0;
	bit  req_wait = 1'b0;  // a request is on the bus and not yet taken
	int  quiet_cycles = 0;

	function automatic void pool_reinit();
		longint b, l;
		b = pool_base_q & (SPACE - 1);
		l = pool_size_q;
		if (l > SPACE - b) l = SPACE - b;
		seg_n = 0;
		if (l > 0) begin
			seg_b[0] = b;
			seg_l[0] = l;
			seg_n = 1;
		end
		for (int i = 0; i < NREC; i++) rec_v[i] = 1'b0;
		live_n = 0;
	endfunction

	function automatic void seg_drop(int k);
		for (int i = k; i + 1 < seg_n; i++) begin
			seg_b[i] = seg_b[i + 1];
			seg_l[i] = seg_l[i + 1];
		end
		seg_n--;
	endfunction

	// Works out the response to one request and updates the shadow pool.
	function automatic alloc_rsp_t allocator_predict(alloc_req_t rq);
		alloc_rsp_t rs;
		longint a, b, p, need, s, l;
		int r, k;
		bit mp, mn;
		rs.status = ST_OK;
		rs.data_addr = '0;
		if (rq.op == OP_ALLOC) begin
			a = 64'd1 << rq.align_log2;
			for (r = 0; r < NREC; r++) if (!rec_v[r]) break;
			if (r >= NREC) rs.status = ST_FULL;
			else begin
				rs.status = ST_NO_FIT;
				for (int i = 0; i < seg_n; i++) begin
					b = seg_b[i];
					p = HDR + ((a - ((b + HDR) & (a - 1))) & (a - 1));
					need = rq.req_size + p;
					if (seg_l[i] >= need) begin
						if (seg_l[i] > need) begin
							seg_b[i] = b + need;
							seg_l[i] -= need;
						end else seg_drop(i);
						rec_v[r] = 1'b1;
						rec_d[r] = (b + p) & (SPACE - 1);
						rec_s[r] = b;
						rec_l[r] = need;
						live_n++;
						rs.status = ST_OK;
						rs.data_addr = rec_d[r][19:0];
						break;
					end
				end
			end
		end else begin
			for (r = 0; r < NREC; r++) if (rec_v[r] && rec_d[r] == rq.free_addr) break;
			if (r >= NREC) rs.status = ST_UNKNOWN;
			else begin
				s = rec_s[r];
				l = rec_l[r];
				for (k = 0; k < seg_n; k++) if (seg_b[k] > s) break;
				mn = k < seg_n && s + l == seg_b[k];
				mp = k > 0 && seg_b[k - 1] + seg_l[k - 1] == s;
				if (!mn && !mp && seg_n >= NSEG) rs.status = ST_FULL;
				else begin
					if (mp && mn) begin
						seg_l[k - 1] += l + seg_l[k];
						seg_drop(k);
					end else if (mp) seg_l[k - 1] += l;
					else if (mn) begin
						seg_b[k] = s;
						seg_l[k] += l;
					end else begin
						for (int i = seg_n; i > k; i--) begin
							seg_b[i] = seg_b[i - 1];
							seg_l[i] = seg_l[i - 1];
						end
						seg_b[k] = s;
						seg_l[k] = l;
						seg_n++;
					end
					rec_v[r] = 1'b0;
					live_n--;
				end
			end
		end
		rs.live_count = live_n[4:0];
		return rs;
	endfunction

	// Driver: requests change on the falling edge. Prediction happens at
	// acceptance so the expected order follows the real one.
	initial begin
		req_ch.valid = 1'b0;
		req_ch.op = OP_ALLOC;
		req_ch.req_size = '0;
		req_ch.align_log2 = '0;
		req_ch.free_addr = '0;
		rsp_ch.ready = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && req_ch.valid && req_ch.ready) begin
			expected_rsps.push_back(allocator_predict(
				{req_ch.op, req_ch.req_size, req_ch.align_log2, req_ch.free_addr}));
			void'(pending_reqs.pop_front());
			req_wait = 1'b0;
		end
	end

	always @(negedge clk) begin
		alloc_req_t nx;
		// an untaken request stays on the bus unchanged
		if (!req_wait) begin
			if (!arst_n || send_hold || pending_reqs.size() == 0
					|| $urandom_range(99) < send_idle_pct) begin
				req_ch.valid <= 1'b0;
			end else begin
				nx = pending_reqs[0];
				req_ch.valid <= 1'b1;
				req_ch.op <= nx.op;
				req_ch.req_size <= nx.req_size;
				req_ch.align_log2 <= nx.align_log2;
				req_ch.free_addr <= nx.free_addr;
				req_wait = 1'b1;
			end
		end
		rsp_ch.ready <= arst_n && ($urandom_range(99) >= recv_stall_pct);
	end

	// Monitor: compare each response with the oldest expectation.
	always @(posedge clk) begin
		alloc_rsp_t exp_r;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (expected_rsps.size() == 0) begin
				$error("unexpected response status=%0d", rsp_ch.status);
				errors++;
			end else begin
				exp_r = expected_rsps.pop_front();
				if (rsp_ch.status !== exp_r.status) begin
					$error("status exp %0d got %0d", exp_r.status, rsp_ch.status);
					errors++;
				end
				if (rsp_ch.data_addr !== exp_r.data_addr) begin
					$error("data_addr exp %h got %h", exp_r.data_addr, rsp_ch.data_addr);
					errors++;
				end
				if (rsp_ch.live_count !== exp_r.live_count) begin
					$error("live_count exp %0d got %0d", exp_r.live_count,
						rsp_ch.live_count);
					errors++;
				end
			end
		end
	end

	// Watchdog: counts cycles with no handshake on either side.
	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
			quiet_cycles <= 0;
		else if (arst_n && (pending_reqs.size() != 0 || expected_rsps.size() != 0)) begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= IDLE_LIMIT) begin
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	task automatic wait_drained();
		while (pending_reqs.size() != 0 || expected_rsps.size() != 0 || req_ch.valid)
			@(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_POOL_BASE) pool_base_q = val[19:0];
		else pool_size_q = val;
		pool_reinit();
	endtask

	function automatic void push_alloc(int sz, int lg);
		alloc_req_t rq;
		rq.op = OP_ALLOC;
		rq.req_size = 21'(sz);
		rq.align_log2 = 4'(lg);
		rq.free_addr = 20'($urandom);
		pending_reqs.push_back(rq);
	endfunction

	function automatic void push_free(logic [19:0] fa);
		alloc_req_t rq;
		rq.op = OP_FREE;
		rq.req_size = 21'($urandom);
		rq.align_log2 = 4'($urandom);
		rq.free_addr = fa;
		pending_reqs.push_back(rq);
	endfunction

	task automatic random_phase(int n);
		int sz, lg, idx;
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(9))
				0, 1, 2, 3: begin
					sz = ($urandom_range(19) == 0) ? int'($urandom_range(2097151)) :
						int'($urandom_range(4096));
					lg = ($urandom_range(9) == 0) ? int'($urandom_range(15)) :
						int'($urandom_range(12));
					push_alloc(sz, lg);
				end
				4, 5, 6, 7: begin
					if ($urandom_range(3) != 0) begin
						// pick a live record after draining the queue so state is exact
						wait_drained();
						if (live_n > 0) begin
							idx = int'($urandom_range(NREC - 1));
							while (!rec_v[idx]) idx = (idx + 1) % NREC;
							push_free(rec_d[idx][19:0]);
						end else push_free(20'($urandom));
					end else push_free(20'($urandom));
				end
				default: begin
					push_alloc(int'($urandom_range(64)), int'($urandom_range(4)));
				end
			endcase
		end
		wait_drained();
	endtask

	initial begin
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		pool_reinit();
		send_idle_pct = 30;
		recv_stall_pct = 55;

		// Directed: extremes, zero size, large alignment, full tables, frees.
		push_alloc(0, 0);
		push_alloc(2097151, 15);
		push_alloc(1048576, 0);
		push_alloc(16, 15);
		push_free(20'hFFFFF);
		push_free(20'h0);
		for (int i = 0; i < 15; i++) push_alloc(1, i % 13);
		wait_drained();
		// records are now full; free two, then free one of them a second time
		push_free(rec_d[3][19:0]);
		push_free(rec_d[0][19:0]);
		push_free(rec_d[3][19:0]);
		wait_drained();

		// Small pool near the top of the address space: clipping, exact fit.
		cfg_write(REG_POOL_BASE, 21'h0FFF00);
		cfg_write(REG_POOL_SIZE, 21'h1FFFFF);
		push_alloc(248, 0);
		push_alloc(1, 0);
		wait_drained();
		push_free(rec_d[0][19:0]);
		wait_drained();
		cfg_write(REG_POOL_SIZE, 21'd0);
		push_alloc(0, 0);
		wait_drained();
		cfg_write(REG_POOL_BASE, 21'd0);
		cfg_write(REG_POOL_SIZE, 21'd1);
		push_alloc(0, 0);
		wait_drained();

		// Fragment a mid pool so the record table fills, then free every other record.
		cfg_write(REG_POOL_BASE, 21'h12345);
		cfg_write(REG_POOL_SIZE, 21'd3000);
		for (int i = 0; i < 16; i++) push_alloc(40 + i, i % 4);
		wait_drained();
		for (int i = 0; i < 16; i += 2) push_free(rec_d[i][19:0]);
		wait_drained();
		random_phase(150);

		send_idle_pct = 55;
		recv_stall_pct = 30;
		cfg_write(REG_POOL_SIZE, 21'd1048576);
		cfg_write(REG_POOL_BASE, 21'h00400);
		random_phase(150);

		send_idle_pct = 0;
		recv_stall_pct = 0;
		cfg_write(REG_POOL_BASE, 21'h0);
		cfg_write(REG_POOL_SIZE, 21'd2048);
		// hold the sender until everything outstanding has answered
		push_alloc(100, 3);
		push_alloc(60, 2);
		push_alloc(30, 4);
		push_alloc(12, 0);
		while (expected_rsps.size() == 0) @(posedge clk);
		send_hold = 1'b1;
		while (expected_rsps.size() != 0) @(posedge clk);
		send_hold = 1'b0;
		random_phase(150);

		wait_drained();
		if (errors == 0) $display("[ OK ] regression clean");
		else $display("[FAIL] regression broken");
		$finish;
	end
endmodule

// ===== sim.f =====
hw/rtl/ffa_pkg.sv
hw/rtl/ffa_if.sv
hw/rtl/ffa_ram.sv
hw/rtl/first_fit_free_list_allocator_core.sv
bench/tb_first_fit_free_list_allocator_core.sv
